// ===== rtl/console_pad_mouse_serial_port_assert.svh =====
// Assertion macros for the controller port block.
// Included by the top level; no other dependencies.
`ifndef CONSOLE_PAD_MOUSE_SERIAL_PORT_ASSERT_SVH
`define CONSOLE_PAD_MOUSE_SERIAL_PORT_ASSERT_SVH
`ifndef SYNTH
`define CPMSP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define CPMSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPMSP_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define CPMSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/cpmsp_pkg.sv =====
// Shared types and constants for the controller port block.
// No dependencies.
package cpmsp_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD_PAD = 2'd0,
    MODE_MOTION   = 2'd1,
    MODE_LATCH    = 2'd2,
    MODE_READ     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DEV_NONE  = 2'd0,
    DEV_PAD   = 2'd1,
    DEV_MOUSE = 2'd2,
    DEV_GUN   = 2'd3
  } dev_t;

  localparam int unsigned SENS_LSB      = 20;
  localparam logic [6:0]  MAG_MAX       = 7'h7f;
  localparam logic [31:0] PAD_FILL      = 32'h0000_8000;
  localparam logic        MOUSE_SIG_BIT = 1'b1;

  typedef struct packed {
    mode_t              mode;
    logic [31:0]        pad_state;
    logic signed [15:0] motion_x;
    logic signed [15:0] motion_y;
    logic               button_left;
    logic               button_right;
    logic               latch_level;
  } item_t;

endpackage

// ===== rtl/cpmsp_if.sv =====
// Valid/ready channel interfaces for the controller port block.
// Depends on nothing; payload widths follow the port's item and result fields.
interface cpmsp_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [31:0]        pad_state;
  logic signed [15:0] motion_x;
  logic signed [15:0] motion_y;
  logic               button_left;
  logic               button_right;
  logic               latch_level;

  modport source (output valid, mode, pad_state, motion_x, motion_y, button_left,
                  button_right, latch_level, input ready);
  modport sink (input valid, mode, pad_state, motion_x, motion_y, button_left,
                button_right, latch_level, output ready);
endinterface

interface cpmsp_result_if;
  logic valid;
  logic ready;
  logic data_bit;

  modport source (output valid, data_bit, input ready);
  modport sink (input valid, data_bit, output ready);
endinterface

// ===== rtl/cpmsp_axis.sv =====
// One mouse axis: motion to sticky-sign / clamped-magnitude byte.
// Depends on cpmsp_pkg.
module cpmsp_axis
  import cpmsp_pkg::*;
(
  input  logic signed [15:0] motion,
  input  logic               sign_cur,
  output logic               sign_next,
  output logic [7:0]         axis_byte
);

  logic [7:0] coarse;
  logic [7:0] neg;
  logic [6:0] mag;

  // arithmetic shift by 8 keeps the high byte
  assign coarse = motion[15:8];
  assign neg    = ~coarse + 8'd1;

  always_comb begin
    if (!coarse[7]) begin
      mag = coarse[6:0];
    end else if (neg[7]) begin
      mag = MAG_MAX;
    end else begin
      mag = neg[6:0];
    end
  end

  // hold the previous sign when there is no motion
  assign sign_next = (coarse != 8'd0) ? coarse[7] : sign_cur;
  assign axis_byte = {sign_next, mag};

endmodule

// ===== rtl/cpmsp_core.sv =====
// Port state (latch, shift and live words, mouse signs, sensitivity) and
// the per-item update. Depends on cpmsp_pkg and cpmsp_axis.
module cpmsp_core
  import cpmsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  item_t item,
  input  dev_t  device_kind,
  output logic  data_bit
);

  logic        latch_high, latch_high_next;
  logic [31:0] shift_word, shift_word_next;
  logic [31:0] live_word, live_word_next;
  logic        sign_x, sign_x_next;
  logic        sign_y, sign_y_next;
  logic [7:0]  sens_count, sens_count_next;
  logic [1:0]  sens_mod3, sens_mod3_next;

  logic        ax_sign, ay_sign;
  logic [7:0]  ax_byte, ay_byte;
  logic [31:0] read_word;
  logic [31:0] live_sens;

  cpmsp_axis u_axis_x (
    .motion    (item.motion_x),
    .sign_cur  (sign_x),
    .sign_next (ax_sign),
    .axis_byte (ax_byte)
  );

  cpmsp_axis u_axis_y (
    .motion    (item.motion_y),
    .sign_cur  (sign_y),
    .sign_next (ay_sign),
    .axis_byte (ay_byte)
  );

  assign read_word = latch_high ? live_word : shift_word;

  always_comb begin
    live_sens = live_word;
    live_sens[SENS_LSB +: 2] = sens_mod3;
  end

  always_comb begin
    latch_high_next = latch_high;
    shift_word_next = shift_word;
    live_word_next  = live_word;
    sign_x_next     = sign_x;
    sign_y_next     = sign_y;
    sens_count_next = sens_count;
    sens_mod3_next  = sens_mod3;
    data_bit        = 1'b0;
    case (item.mode)
      MODE_LOAD_PAD: begin
        live_word_next = item.pad_state;
      end
      MODE_MOTION: begin
        sign_x_next    = ax_sign;
        sign_y_next    = ay_sign;
        live_word_next = {8'h00, item.button_right, item.button_left, sens_mod3,
                          3'b000, MOUSE_SIG_BIT, ay_byte, ax_byte};
      end
      MODE_LATCH: begin
        if (item.latch_level) begin
          shift_word_next = live_word;
          if (device_kind == DEV_MOUSE) begin
            live_word_next = live_sens;
          end
        end
        latch_high_next = item.latch_level;
      end
      MODE_READ: begin
        case (device_kind)
          DEV_NONE: begin
            latch_high_next = 1'b0;
            shift_word_next = '0;
            live_word_next  = '0;
            sign_x_next     = 1'b0;
            sign_y_next     = 1'b0;
            sens_count_next = '0;
            sens_mod3_next  = '0;
          end
          DEV_MOUSE: begin
            if (latch_high) begin
              live_word_next  = live_sens;
              sens_count_next = sens_count + 8'd1;
              // 256 is not a multiple of 3: the wrap restarts the residue at zero
              if (sens_count == 8'hff || sens_mod3 == 2'd2) begin
                sens_mod3_next = 2'd0;
              end else begin
                sens_mod3_next = sens_mod3 + 2'd1;
              end
            end
            data_bit        = read_word[31];
            shift_word_next = {read_word[30:0], 1'b1};
          end
          default: begin
            data_bit        = read_word[0];
            shift_word_next = {1'b0, read_word[31:1]} | PAD_FILL;
          end
        endcase
      end
      default: begin
        live_word_next = live_word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch_high <= 1'b0;
      shift_word <= '0;
      live_word  <= '0;
      sign_x     <= 1'b0;
      sign_y     <= 1'b0;
      sens_count <= '0;
      sens_mod3  <= '0;
    end else if (step) begin
      latch_high <= latch_high_next;
      shift_word <= shift_word_next;
      live_word  <= live_word_next;
      sign_x     <= sign_x_next;
      sign_y     <= sign_y_next;
      sens_count <= sens_count_next;
      sens_mod3  <= sens_mod3_next;
    end
  end

endmodule

// ===== rtl/console_pad_mouse_serial_port.sv =====
// Top level of the controller port: input register, core, result register.
// Depends on cpmsp_pkg, cpmsp_if, cpmsp_core and the assertion macro header.
//
// Usage:
//   item   - valid/ready sink carrying one port event: load pad word, mouse
//            motion, latch line level, or serial read.
//   result - valid/ready source carrying data_bit; only a read makes one.
//   cfg_we / cfg_wdata - write the attached device kind; change it only while
//            the block is idle.
// Order: an item is registered on transfer and applied to the port state when it
// leaves the input register; a read's data_bit is loaded into the result
// register at that same edge, which sets result valid.
// Throughput: one item per cycle while no read waits on the result register;
// every event is a single update of the port state as it leaves the input register.
// Stall: while the result register holds an untaken bit, a registered read
// waits and item ready drops; load, motion and latch items keep flowing.
// Reset: all port state clears, the device kind returns to gamepad and both
// registers empty.
`include "console_pad_mouse_serial_port_assert.svh"

module console_pad_mouse_serial_port
  import cpmsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  cpmsp_item_if.sink            item,
  cpmsp_result_if.source        result,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_wdata
);

  dev_t  device_kind;
  item_t item_r;
  logic  item_vld;
  logic  advance;
  logic  stage_read;
  logic  core_bit;
  logic  res_vld;
  logic  res_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_kind <= DEV_PAD;
    end else if (cfg_we) begin
      device_kind <= dev_t'(cfg_wdata);
    end
  end

  assign stage_read = (item_r.mode == MODE_READ);
  // hold a read while the previous bit is still waiting
  assign advance    = item_vld && !(stage_read && res_vld && !result.ready);
  assign item.ready = !item_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (item.valid && item.ready) begin
      item_vld <= 1'b1;
    end else if (advance) begin
      item_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_r.mode         <= mode_t'(item.mode);
      item_r.pad_state    <= item.pad_state;
      item_r.motion_x     <= item.motion_x;
      item_r.motion_y     <= item.motion_y;
      item_r.button_left  <= item.button_left;
      item_r.button_right <= item.button_right;
      item_r.latch_level  <= item.latch_level;
    end
  end

  cpmsp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (item_r),
    .device_kind (device_kind),
    .data_bit    (core_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance && stage_read) begin
      res_vld <= 1'b1;
    end else if (result.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_read) begin
      res_bit <= core_bit;
    end
  end

  assign result.valid    = res_vld;
  assign result.data_bit = res_bit;

  `CPMSP_ASSERT_NEXT(a_read_fills_result, clk, rst, advance && stage_read, res_vld && res_bit == $past(core_bit), "read did not load the result register")
  `CPMSP_ASSERT_NEXT(a_other_keeps_result, clk, rst, advance && !stage_read && res_vld && !result.ready, res_vld, "non-read item dropped a waiting result")
  `CPMSP_ASSERT_SAME(a_empty_stage_ready, clk, rst, !item_vld, item.ready, "empty input register refused a transfer")
  `CPMSP_ASSERT_SAME(a_no_device_zero, clk, rst, advance && stage_read && device_kind == DEV_NONE, !core_bit, "read with no device returned one")

endmodule
